>>> rtl/tscc_pkg.sv
package tscc_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int MAX_POWER_DEF = 63;

    // pi / 648000 scaled by 2^56, split for a 32 x 20 multiplier.
    localparam logic [38:0] RAD_PER_ARCSEC_Q56 = 39'd349345074174;
    localparam logic [19:0] RAD_K_LO = RAD_PER_ARCSEC_Q56[19:0];
    localparam logic [19:0] RAD_K_HI = {1'b0, RAD_PER_ARCSEC_Q56[38:20]};

    localparam logic [5:0]  HIGHEST_POWER_RESET = 6'd21;
    localparam logic [30:0] TERM_LIMIT = 31'h7FFF_FFFF;
    localparam logic signed [31:0] POS_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_LIMIT = 32'sh8000_0000;

    // Each series term runs a 36-bit division, four quotient bits a cycle.
    localparam int TERM_DIV_BITS = 36;
    localparam int TERM_DIV_RADIX = 4;
    localparam int TERM_DIV_CYCLES = TERM_DIV_BITS / TERM_DIV_RADIX;

endpackage

>>> rtl/taylor_sine_cosine_tangent_core.sv
// Channel  Direction  Contents
// s_axis   in         tdata: degrees[8:0], minutes[14:9], seconds[20:15]
// m_axis   out        tdata: sine, cosine, tangent; tuser: tangent_saturated
// cfg      in         cfg_we / cfg_wdata: highest_power
//
// A word is converted to radians, then summed term by term up to P, the
// clamped highest power. Each term needs two passes of the shared 32 x 20
// multiplier and a radix-16 division by n; the tangent uses a one bit per
// cycle divider. Reset restores highest_power to 21.
// A new word is taken only when the core is idle; a finished result waits in
// the output register while the next word is already being computed.
module taylor_sine_cosine_tangent_core
    import tscc_pkg::*;
#(
    parameter int MAX_POWER = MAX_POWER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // degrees[8:0], minutes[14:9], seconds[20:15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // sine[31:0], cosine[63:32], tangent[95:64]
    output logic [0:0]  m_tuser,   // tangent_saturated[0]
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    localparam int SHIFT = 56 - FRAC_BITS;
    localparam int XW    = FRAC_BITS + 4;
    localparam int TNW   = 32 + FRAC_BITS;
    localparam int TCW   = $clog2(TNW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_XLO, ST_XHI, ST_TLO, ST_THI, ST_TDIV, ST_TACC,
        ST_SUMS, ST_TPREP, ST_TANDIV, ST_TSAT, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [5:0]         hp_reg, hp_next;
    logic [20:0]        total_reg, total_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [30:0]        term_reg, term_next;
    logic [5:0]         n_reg, n_next;
    logic [5:0]         limit_reg, limit_next;
    logic [63:0]        acc_reg, acc_next;
    logic signed [38:0] sin_reg, sin_next;
    logic signed [38:0] cos_reg, cos_next;
    logic [35:0]        dq_reg, dq_next;
    logic [5:0]         dr_reg, dr_next;
    logic [3:0]         dcnt_reg, dcnt_next;
    logic signed [31:0] sine_reg, sine_next;
    logic signed [31:0] cosine_reg, cosine_next;
    logic signed [31:0] tan_reg, tan_next;
    logic               flag_reg, flag_next;
    logic               neg_reg, neg_next;
    logic [TNW-1:0]     tq_reg, tq_next;
    logic [31:0]        tr_reg, tr_next;
    logic [31:0]        tden_reg, tden_next;
    logic [TCW-1:0]     tcnt_reg, tcnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [95:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic [31:0]        mul_a;
    logic [19:0]        mul_b;
    logic [51:0]        prod;
    logic [35:0]        dq_w;
    logic [5:0]         dr_w;
    logic [6:0]         trial;
    logic [32:0]        ttrial;
    logic [30:0]        term_sat;
    logic signed [38:0] term_signed;
    logic [31:0]        sine_abs;
    logic [31:0]        cosine_abs;
    logic signed [31:0] sine_cl;
    logic signed [31:0] cosine_cl;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = {11'd0, total_reg};
        mul_b = RAD_K_LO;
        case (state_reg)
            ST_XLO: mul_b = RAD_K_LO;
            ST_XHI: mul_b = RAD_K_HI;
            ST_TLO:
            begin
                mul_a = {1'b0, term_reg};
                mul_b = {4'd0, x_reg[15:0]};
            end
            ST_THI:
            begin
                mul_a = {1'b0, term_reg};
                mul_b = 20'(x_reg[XW-1:16]);
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Four restoring steps of the term division by n.
    always_comb
    begin
        dq_w = dq_reg;
        dr_w = dr_reg;
        trial = 7'd0;
        for (int i = 0; i < TERM_DIV_RADIX; i++)
        begin
            trial = {dr_w, dq_w[35]};
            if (trial >= {1'b0, n_reg})
            begin
                dr_w = 6'(trial - {1'b0, n_reg});
                dq_w = {dq_w[34:0], 1'b1};
            end
            else
            begin
                dr_w = trial[5:0];
                dq_w = {dq_w[34:0], 1'b0};
            end
        end
    end

    assign ttrial      = {tr_reg, tq_reg[TNW-1]};
    assign term_sat    = (dq_reg > {5'd0, TERM_LIMIT}) ? TERM_LIMIT : dq_reg[30:0];
    assign term_signed = n_reg[1] ? -$signed({8'd0, term_sat}) : $signed({8'd0, term_sat});
    assign sine_abs    = sine_reg[31] ? 32'(-sine_reg) : 32'(sine_reg);
    assign cosine_abs  = cosine_reg[31] ? 32'(-cosine_reg) : 32'(cosine_reg);
    assign sine_cl     = (sin_reg > 39'sd2147483647) ? POS_LIMIT :
                         (sin_reg < -39'sd2147483648) ? NEG_LIMIT : 32'(sin_reg);
    assign cosine_cl   = (cos_reg > 39'sd2147483647) ? POS_LIMIT :
                         (cos_reg < -39'sd2147483648) ? NEG_LIMIT : 32'(cos_reg);

    always_comb
    begin
        state_next    = state_reg;
        hp_next       = cfg_we ? cfg_wdata : hp_reg;
        total_next    = total_reg;
        x_next        = x_reg;
        term_next     = term_reg;
        n_next        = n_reg;
        limit_next    = limit_reg;
        acc_next      = acc_reg;
        sin_next      = sin_reg;
        cos_next      = cos_reg;
        dq_next       = dq_reg;
        dr_next       = dr_reg;
        dcnt_next     = dcnt_reg;
        sine_next     = sine_reg;
        cosine_next   = cosine_reg;
        tan_next      = tan_reg;
        flag_next     = flag_reg;
        neg_next      = neg_reg;
        tq_next       = tq_reg;
        tr_next       = tr_reg;
        tden_next     = tden_reg;
        tcnt_next     = tcnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    total_next = 21'({12'd0, s_tdata[8:0]} * 21'd3600)
                               + 21'({15'd0, s_tdata[14:9]} * 21'd60)
                               + {15'd0, s_tdata[20:15]};
                    limit_next = (hp_reg > 6'(MAX_POWER)) ? 6'(MAX_POWER) : hp_reg;
                    term_next  = 31'(1) << FRAC_BITS;
                    n_next     = 6'd1;
                    sin_next   = '0;
                    cos_next   = 39'sd1 <<< FRAC_BITS;
                    state_next = ST_XLO;
                end
            end
            ST_XLO:
            begin
                acc_next   = {12'd0, prod} + (64'd1 << (SHIFT - 1));
                state_next = ST_XHI;
            end
            ST_XHI:
            begin
                acc_next   = acc_reg + ({12'd0, prod} << 20);
                x_next     = acc_next[SHIFT +: XW];
                state_next = (limit_reg == 6'd0) ? ST_SUMS : ST_TLO;
            end
            ST_TLO:
            begin
                // The rounding offset n * 2^(F-1) is folded in up front.
                acc_next   = {12'd0, prod} + ({58'd0, n_reg} << (FRAC_BITS - 1));
                state_next = ST_THI;
            end
            ST_THI:
            begin
                acc_next   = acc_reg + ({12'd0, prod} << 16);
                dq_next    = acc_next[FRAC_BITS +: 36];
                dr_next    = '0;
                dcnt_next  = '0;
                state_next = ST_TDIV;
            end
            ST_TDIV:
            begin
                dq_next   = dq_w;
                dr_next   = dr_w;
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'(TERM_DIV_CYCLES - 1))
                begin
                    state_next = ST_TACC;
                end
            end
            ST_TACC:
            begin
                term_next = term_sat;
                if (n_reg[0])
                begin
                    sin_next = sin_reg + term_signed;
                end
                else
                begin
                    cos_next = cos_reg + term_signed;
                end
                if (n_reg == limit_reg)
                begin
                    state_next = ST_SUMS;
                end
                else
                begin
                    n_next     = n_reg + 6'd1;
                    state_next = ST_TLO;
                end
            end
            ST_SUMS:
            begin
                sine_next   = sine_cl;
                cosine_next = cosine_cl;
                state_next  = ST_TPREP;
            end
            ST_TPREP:
            begin
                flag_next = 1'b0;
                neg_next  = sine_reg[31] != cosine_reg[31];
                if (cosine_reg == 32'sd0)
                begin
                    flag_next  = 1'b1;
                    tan_next   = sine_reg[31] ? NEG_LIMIT : POS_LIMIT;
                    state_next = ST_FIN;
                end
                else
                begin
                    tq_next    = {sine_abs, FRAC_BITS'(0)};
                    tr_next    = '0;
                    tden_next  = cosine_abs;
                    tcnt_next  = '0;
                    state_next = ST_TANDIV;
                end
            end
            ST_TANDIV:
            begin
                if (ttrial >= {1'b0, tden_reg})
                begin
                    tr_next = 32'(ttrial - {1'b0, tden_reg});
                    tq_next = {tq_reg[TNW-2:0], 1'b1};
                end
                else
                begin
                    tr_next = ttrial[31:0];
                    tq_next = {tq_reg[TNW-2:0], 1'b0};
                end
                tcnt_next = tcnt_reg + 1'b1;
                if (tcnt_reg == TCW'(TNW - 1))
                begin
                    state_next = ST_TSAT;
                end
            end
            ST_TSAT:
            begin
                if (neg_reg)
                begin
                    if (tq_reg > TNW'(64'h8000_0000))
                    begin
                        flag_next = 1'b1;
                        tan_next  = NEG_LIMIT;
                    end
                    else
                    begin
                        tan_next = 32'(-tq_reg);
                    end
                end
                else
                begin
                    if (tq_reg > TNW'(64'h7FFF_FFFF))
                    begin
                        flag_next = 1'b1;
                        tan_next  = POS_LIMIT;
                    end
                    else
                    begin
                        tan_next = 32'(tq_reg);
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {tan_reg, cosine_reg, sine_reg};
                    m_tuser_next  = flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hp_reg       <= HIGHEST_POWER_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hp_reg       <= hp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        x_reg       <= x_next;
        term_reg    <= term_next;
        n_reg       <= n_next;
        limit_reg   <= limit_next;
        acc_reg     <= acc_next;
        sin_reg     <= sin_next;
        cos_reg     <= cos_next;
        dq_reg      <= dq_next;
        dr_reg      <= dr_next;
        dcnt_reg    <= dcnt_next;
        sine_reg    <= sine_next;
        cosine_reg  <= cosine_next;
        tan_reg     <= tan_next;
        flag_reg    <= flag_next;
        neg_reg     <= neg_next;
        tq_reg      <= tq_next;
        tr_reg      <= tr_next;
        tden_reg    <= tden_next;
        tcnt_reg    <= tcnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

>>> dv/taylor_sine_cosine_tangent_core_test.sv
module taylor_sine_cosine_tangent_core_test
    import tscc_pkg::*;
;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [8:0] degrees;
    } angle_t;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
        logic signed [31:0] tangent;
        logic               saturated;
    } trig_t;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 5000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;

    angle_t     pending_angles[$];
    trig_t      expected_trig[$];
    logic [5:0] highest_power;
    logic [5:0] powers[8] = '{6'd21, 6'd0, 6'd63, 6'd1, 6'd2, 6'd9, 6'd40, 6'd15};
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off_cycles;
    int         mismatch_count;
    longint     cycle_count;

    taylor_sine_cosine_tangent_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic trig_t predict_trig(angle_t a, logic [5:0] power);
        logic [63:0]  arcsec;
        logic [127:0] wide;
        logic [63:0]  x;
        logic [127:0] term;
        logic [127:0] divisor;
        longint       sin_sum;
        longint       cos_sum;
        longint       sv;
        longint       cv;
        logic [127:0] quo;
        int           limit;
        bit           negative;
        trig_t        r;
        arcsec = 64'(a.degrees) * 3600 + 64'(a.minutes) * 60 + 64'(a.seconds);
        wide = 128'(arcsec) * 128'(RAD_PER_ARCSEC_Q56) + (128'd1 << (55 - FRAC));
        x = 64'(wide >> (56 - FRAC));
        limit = (power > MAX_POWER_DEF) ? MAX_POWER_DEF : power;
        term = 128'd1 << FRAC;
        sin_sum = 0;
        cos_sum = longint'(1) << FRAC;
        for (int n = 1; n <= limit; n++)
        begin
            divisor = 128'(n) << FRAC;
            term = (term * 128'(x) + (divisor >> 1)) / divisor;
            if (term > 128'h7FFF_FFFF)
                term = 128'h7FFF_FFFF;
            // Terms for powers 2 and 3 modulo 4 are subtracted.
            if (n % 2 == 1)
                sin_sum += ((n % 4) >= 2) ? -longint'(term) : longint'(term);
            else
                cos_sum += ((n % 4) >= 2) ? -longint'(term) : longint'(term);
        end
        sv = clamp_word(sin_sum);
        cv = clamp_word(cos_sum);
        r.sine = 32'(sv);
        r.cosine = 32'(cv);
        r.saturated = 1'b0;
        negative = (sv < 0) != (cv < 0);
        if (cv == 0)
        begin
            r.saturated = 1'b1;
            r.tangent = (sv < 0) ? NEG_LIMIT : POS_LIMIT;
        end
        else
        begin
            quo = (128'(sv < 0 ? -sv : sv) << FRAC) / 128'(cv < 0 ? -cv : cv);
            if (negative && quo > 128'd2147483648)
            begin
                r.saturated = 1'b1;
                r.tangent = NEG_LIMIT;
            end
            else if (!negative && quo > 128'd2147483647)
            begin
                r.saturated = 1'b1;
                r.tangent = POS_LIMIT;
            end
            else
                r.tangent = negative ? -32'(quo) : 32'(quo);
        end
        return r;
    endfunction

    // Driver: a word stays offered until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_trig.push_back(predict_trig(angle_t'(s_tdata[20:0]), highest_power));
            if ((!s_tvalid || s_tready) && pending_angles.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, pending_angles.pop_front()};
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // Monitor.
    always @(posedge clk)
    begin
        trig_t got;
        trig_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
            if (expected_trig.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: %h", got);
            end
            else
            begin
                want = expected_trig.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: sin %h/%h cos %h/%h tan %h/%h sat %b/%b",
                            want.sine, got.sine, want.cosine, got.cosine,
                            want.tangent, got.tangent, want.saturated, got.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_angles.size() > 0 || s_tvalid || expected_trig.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_power(logic [5:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        highest_power <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic angle_t random_angle();
        angle_t a;
        case ($urandom_range(9))
            0: a = angle_t'(21'($urandom));
            1: a = '{seconds: 6'd0, minutes: 6'd0, degrees: 9'($urandom_range(3) * 90)};
            default: a = '{seconds: 6'($urandom_range(59)), minutes: 6'($urandom_range(59)),
                           degrees: 9'($urandom_range(359))};
        endcase
        return a;
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_angles.push_back(random_angle());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        highest_power = HIGHEST_POWER_RESET;
        send_idle_pct = 33;
        recv_idle_pct = 77;
        hold_off_cycles = 0;
        mismatch_count = 0;
        cycle_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Spot angles at the reset power: zero, right angles, field maxima and others.
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd0});
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd90});
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd180});
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd270});
        pending_angles.push_back('{seconds: 6'd59, minutes: 6'd59, degrees: 9'd359});
        pending_angles.push_back('{seconds: 6'd63, minutes: 6'd63, degrees: 9'd511});
        pending_angles.push_back('{seconds: 6'd1, minutes: 6'd0, degrees: 9'd0});
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd59, degrees: 9'd89});
        pending_angles.push_back('{seconds: 6'd30, minutes: 6'd0, degrees: 9'd45});
        pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd400});
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 33;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_power(powers[p]);
            pending_angles.push_back('{seconds: 6'd0, minutes: 6'd0, degrees: 9'd90});
            pending_angles.push_back('{seconds: 6'd63, minutes: 6'd63, degrees: 9'd511});
            queue_random(140);
            if (p == 6)
            begin
                hold_off_cycles = 3000;
            end
            wait_drained();
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
